### rtl/bcd_pkg.sv
// ----------------------------------------------------------------------------
// bcd_pkg: shared types and constants for the breakpoint curve difference
// Item and result layouts, command codes, list bracket and status codes.
// ----------------------------------------------------------------------------
package bcd_pkg;

  localparam int FREQ_W = 17;
  localparam int LVL_W  = 16;
  localparam int GAIN_W = 17;
  localparam int STAT_W = 2;

  // input mode codes
  localparam logic [1:0] MODE_CLEAR    = 2'd0;
  localparam logic [1:0] MODE_ADD_MEAS = 2'd1;
  localparam logic [1:0] MODE_ADD_WANT = 2'd2;
  localparam logic [1:0] MODE_QUERY    = 2'd3;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_DUP  = 2'd2;

  localparam logic [FREQ_W-1:0]       HALF_RATE_RST = 17'd24000;
  localparam logic signed [LVL_W-1:0] LVL_MAX       = 16'sh7fff;
  localparam logic signed [LVL_W-1:0] LVL_MIN       = 16'sh8000;

  // quotient bits produced by the serial divider
  localparam int DIV_STEPS = FREQ_W;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_ADD_MEAS,
    OP_ADD_WANT,
    OP_QUERY
  } op_e;

  typedef enum logic [1:0] {
    LOP_CLEAR,
    LOP_ADD,
    LOP_FIND
  } list_op_e;

  typedef struct packed {
    logic [1:0]              mode;
    logic [FREQ_W-1:0]       freq_hz;
    logic signed [LVL_W-1:0] level_db;
  } item_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_db;
    logic [STAT_W-1:0]        status;
  } result_t;

  typedef struct packed {
    op_e                     op;
    logic [FREQ_W-1:0]       freq;
    logic signed [LVL_W-1:0] level;
  } cmd_t;

  typedef struct packed {
    logic [FREQ_W-1:0]       freq;
    logic signed [LVL_W-1:0] level;
  } point_t;

  // interpolation segment (lx,ly)-(hx,hy); lx == hx means "use ly"
  typedef struct packed {
    logic [FREQ_W-1:0]       lx;
    logic signed [LVL_W-1:0] ly;
    logic [FREQ_W-1:0]       hx;
    logic signed [LVL_W-1:0] hy;
  } bracket_t;

  typedef struct packed {
    logic                    start;
    list_op_e                op;
    logic [FREQ_W-1:0]       freq;
    logic signed [LVL_W-1:0] level;
  } list_req_t;

  typedef struct packed {
    logic              done;
    logic [STAT_W-1:0] status;
    bracket_t          brk;
  } list_rsp_t;

endpackage

### rtl/bcd_ram.sv
// ----------------------------------------------------------------------------
// bcd_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bcd_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/bcd_front.sv
// ----------------------------------------------------------------------------
// bcd_front: item intake and decode
// Accepts items, decodes the mode into a command and buffers two commands.
// ----------------------------------------------------------------------------
module bcd_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  bcd_pkg::item_t item_i,
  output logic           cmd_vld_o,
  output bcd_pkg::cmd_t  cmd_o,
  input  logic           cmd_pop_i
);
  import bcd_pkg::*;

  localparam logic [1:0] QFULL = 2'd2;

  cmd_t       slot_q [2];
  cmd_t       cmd_new;
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push_ok, pop_ok;

  always_comb begin
    cmd_new.freq  = item_i.freq_hz;
    cmd_new.level = item_i.level_db;
    case (item_i.mode)
      MODE_CLEAR:    cmd_new.op = OP_CLEAR;
      MODE_ADD_MEAS: cmd_new.op = OP_ADD_MEAS;
      MODE_ADD_WANT: cmd_new.op = OP_ADD_WANT;
      MODE_QUERY:    cmd_new.op = OP_QUERY;
      default:       cmd_new.op = OP_QUERY;
    endcase
  end

  assign full      = (cnt_q == QFULL);
  assign cmd_vld_o = (cnt_q != 2'd0);
  assign cmd_o     = slot_q[rd_ptr_q];
  assign push_ok   = push && !full;
  assign pop_ok    = cmd_pop_i && cmd_vld_o;

  always_comb begin
    cnt_d = cnt_q;
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_ok && !push_ok) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_ok) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_ok) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      slot_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

### rtl/bcd_list.sv
// ----------------------------------------------------------------------------
// bcd_list: one sorted breakpoint list
// Bisection search, sorted insert with shift, and bracket lookup over a RAM.
// ----------------------------------------------------------------------------
module bcd_list #(
  parameter int MAX_POINTS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bcd_pkg::list_req_t          req_i,
  input  logic [bcd_pkg::FREQ_W-1:0]  half_rate_i,
  output bcd_pkg::list_rsp_t          rsp_o
);
  import bcd_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SRCH_RD  = 4'd1;
  localparam logic [3:0] S_SRCH_CMP = 4'd2;
  localparam logic [3:0] S_RD_A     = 4'd3;
  localparam logic [3:0] S_RD_B     = 4'd4;
  localparam logic [3:0] S_BUILD    = 4'd5;
  localparam logic [3:0] S_SH_RD    = 4'd6;
  localparam logic [3:0] S_SH_WR    = 4'd7;
  localparam logic [3:0] S_INS      = 4'd8;

  logic [3:0]              state_q, state_d;
  logic [CW-1:0]           count_q, count_d;
  logic [CW-1:0]           lo_q, lo_d, hi_q, hi_d, idx_q, idx_d;
  logic [CW-1:0]           lo_n, hi_n;
  list_op_e                op_q, op_d;
  logic [FREQ_W-1:0]       f_q, f_d;
  logic signed [LVL_W-1:0] l_q, l_d;
  point_t                  hi_ent_q, hi_ent_d;
  logic [STAT_W-1:0]       status_q, status_d;
  bracket_t                brk_q, brk_d;
  logic                    done_q, done_d;

  logic [CW:0]   mid_sum;
  logic [CW-1:0] mid, lo_m1, idx_m1;
  logic          pos_lt_cnt;
  logic [AW-1:0] addr_a, lo_addr;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  point_t        ram_wdata, rd_ent;
  logic [$bits(point_t)-1:0] ram_rdata;

  bcd_ram #(
    .WIDTH($bits(point_t)),
    .DEPTH(MAX_POINTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_ent     = point_t'(ram_rdata);
  assign mid_sum    = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid        = mid_sum[CW:1];
  assign lo_m1      = lo_q - CW'(1);
  assign idx_m1     = idx_q - CW'(1);
  assign pos_lt_cnt = (lo_q < count_q);
  assign addr_a     = pos_lt_cnt ? lo_q[AW-1:0] : '0;
  assign lo_addr    = (lo_q == '0) ? '0 : lo_m1[AW-1:0];

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    idx_d     = idx_q;
    op_d      = op_q;
    f_d       = f_q;
    l_d       = l_q;
    hi_ent_d  = hi_ent_q;
    status_d  = status_q;
    brk_d     = brk_q;
    done_d    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = idx_q[AW-1:0];
    ram_wdata = rd_ent;
    ram_raddr = addr_a;
    lo_n      = lo_q;
    hi_n      = hi_q;

    case (state_q)
      S_IDLE: begin
        if (req_i.start) begin
          case (req_i.op)
            LOP_CLEAR: begin
              count_d = '0;
            end
            LOP_ADD, LOP_FIND: begin
              op_d    = req_i.op;
              f_d     = req_i.freq;
              l_d     = req_i.level;
              lo_d    = '0;
              hi_d    = count_q;
              state_d = (count_q != '0) ? S_SRCH_RD : S_RD_A;
            end
            default: begin
            end
          endcase
        end
      end

      // lower bound: first index whose frequency is not below f
      S_SRCH_RD: begin
        ram_raddr = mid[AW-1:0];
        state_d   = S_SRCH_CMP;
      end

      S_SRCH_CMP: begin
        if (rd_ent.freq < f_q) begin
          lo_n = mid + CW'(1);
        end else begin
          hi_n = mid;
        end
        lo_d    = lo_n;
        hi_d    = hi_n;
        state_d = (lo_n < hi_n) ? S_SRCH_RD : S_RD_A;
      end

      S_RD_A: begin
        ram_raddr = addr_a;
        state_d   = S_RD_B;
      end

      S_RD_B: begin
        if (op_q == LOP_FIND) begin
          hi_ent_d  = rd_ent;
          ram_raddr = lo_addr;
          state_d   = S_BUILD;
        end else if (pos_lt_cnt && (rd_ent.freq == f_q)) begin
          // same frequency: keep the lower level
          status_d = ST_DUP;
          done_d   = 1'b1;
          state_d  = S_IDLE;
          if (l_q < rd_ent.level) begin
            ram_we    = 1'b1;
            ram_waddr = lo_q[AW-1:0];
            ram_wdata = '{freq: f_q, level: l_q};
          end
        end else if (count_q >= CW'(MAX_POINTS)) begin
          status_d = ST_FULL;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end else begin
          idx_d   = count_q;
          state_d = (count_q > lo_q) ? S_SH_RD : S_INS;
        end
      end

      S_SH_RD: begin
        ram_raddr = idx_m1[AW-1:0];
        state_d   = S_SH_WR;
      end

      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[AW-1:0];
        ram_wdata = rd_ent;
        idx_d     = idx_m1;
        state_d   = (idx_m1 > lo_q) ? S_SH_RD : S_INS;
      end

      S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = lo_q[AW-1:0];
        ram_wdata = '{freq: f_q, level: l_q};
        count_d   = count_q + CW'(1);
        status_d  = ST_OK;
        done_d    = 1'b1;
        state_d   = S_IDLE;
      end

      // rd_ent holds the entry below the lower bound here
      S_BUILD: begin
        status_d = ST_OK;
        done_d   = 1'b1;
        state_d  = S_IDLE;
        if (count_q == '0) begin
          brk_d = '0;
        end else if (lo_q == count_q) begin
          brk_d.lx = rd_ent.freq;
          brk_d.ly = rd_ent.level;
          brk_d.hx = half_rate_i;
          brk_d.hy = '0;
        end else if (hi_ent_q.freq == f_q) begin
          brk_d.lx = f_q;
          brk_d.ly = hi_ent_q.level;
          brk_d.hx = f_q;
          brk_d.hy = hi_ent_q.level;
        end else if (lo_q == '0) begin
          brk_d.lx = '0;
          brk_d.ly = '0;
          brk_d.hx = hi_ent_q.freq;
          brk_d.hy = hi_ent_q.level;
        end else begin
          brk_d.lx = rd_ent.freq;
          brk_d.ly = rd_ent.level;
          brk_d.hx = hi_ent_q.freq;
          brk_d.hy = hi_ent_q.level;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    idx_q    <= idx_d;
    op_q     <= op_d;
    f_q      <= f_d;
    l_q      <= l_d;
    hi_ent_q <= hi_ent_d;
    status_q <= status_d;
    brk_q    <= brk_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.status = status_q;
  assign rsp_o.brk    = brk_q;

endmodule

### rtl/bcd_interp.sv
// ----------------------------------------------------------------------------
// bcd_interp: linear interpolation on one segment
// Registered multiply, serial restoring divide, truncation and saturation.
// ----------------------------------------------------------------------------
module bcd_interp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [bcd_pkg::FREQ_W-1:0]        freq_i,
  input  bcd_pkg::bracket_t                 brk_i,
  output logic                              done_o,
  output logic signed [bcd_pkg::LVL_W-1:0]  level_o
);
  import bcd_pkg::*;

  localparam int PROD_W = 2 * FREQ_W + 1;
  localparam int SUM_W  = FREQ_W + 2;
  localparam int CNT_W  = $clog2(DIV_STEPS);

  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(LVL_MAX);
  localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(LVL_MIN);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_PREP = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]               state_q, state_d;
  logic [FREQ_W-1:0]        dfx_q, dfx_d;
  logic signed [FREQ_W-1:0] dy_q, dy_d;
  logic signed [FREQ_W:0]   dx_q, dx_d;
  logic signed [LVL_W-1:0]  ly_q, ly_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic [FREQ_W-1:0]        den_q, den_d, rem_q, rem_d, quo_q, quo_d;
  logic                     neg_q, neg_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic signed [LVL_W-1:0]  level_q, level_d;
  logic                     done_q, done_d;

  logic signed [FREQ_W:0]   dfx_s;
  logic signed [PROD_W-1:0] num_full;
  logic [PROD_W-2:0]        num_mag;
  logic signed [FREQ_W:0]   dx_abs;
  logic [FREQ_W:0]          trial, trial_sub;
  logic signed [SUM_W-1:0]  q_s, sum;

  assign dfx_s     = $signed({1'b0, dfx_q});
  assign num_full  = prod_q[PROD_W-1] ? -prod_q : prod_q;
  assign num_mag   = num_full[PROD_W-2:0];
  assign dx_abs    = dx_q[FREQ_W] ? -dx_q : dx_q;
  assign trial     = {rem_q, quo_q[FREQ_W-1]};
  assign trial_sub = trial - {1'b0, den_q};
  assign q_s       = neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});
  assign sum       = $signed({{(SUM_W-LVL_W){ly_q[LVL_W-1]}}, ly_q}) + q_s;

  always_comb begin
    state_d = state_q;
    dfx_d   = dfx_q;
    dy_d    = dy_q;
    dx_d    = dx_q;
    ly_d    = ly_q;
    prod_d  = prod_q;
    den_d   = den_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    neg_d   = neg_q;
    cnt_d   = cnt_q;
    level_d = level_q;
    done_d  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          dfx_d   = freq_i - brk_i.lx;
          dy_d    = $signed({brk_i.hy[LVL_W-1], brk_i.hy})
                  - $signed({brk_i.ly[LVL_W-1], brk_i.ly});
          dx_d    = $signed({1'b0, brk_i.hx}) - $signed({1'b0, brk_i.lx});
          ly_d    = brk_i.ly;
          state_d = S_MUL;
        end
      end

      S_MUL: begin
        prod_d  = dfx_s * dy_q;
        state_d = S_PREP;
      end

      S_PREP: begin
        neg_d = prod_q[PROD_W-1] ^ dx_q[FREQ_W];
        if (dx_q == '0) begin
          level_d = ly_q;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (num_mag[PROD_W-2:FREQ_W] >= dx_abs[FREQ_W-1:0]) begin
          // quotient needs more than FREQ_W bits: level saturates
          level_d = (prod_q[PROD_W-1] ^ dx_q[FREQ_W]) ? LVL_MIN : LVL_MAX;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          rem_d   = num_mag[PROD_W-2:FREQ_W];
          quo_d   = num_mag[FREQ_W-1:0];
          den_d   = dx_abs[FREQ_W-1:0];
          cnt_d   = '0;
          state_d = S_DIV;
        end
      end

      S_DIV: begin
        if (trial >= {1'b0, den_q}) begin
          rem_d = trial_sub[FREQ_W-1:0];
          quo_d = {quo_q[FREQ_W-2:0], 1'b1};
        end else begin
          rem_d = trial[FREQ_W-1:0];
          quo_d = {quo_q[FREQ_W-2:0], 1'b0};
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = S_FIN;
        end
      end

      S_FIN: begin
        if (sum > SUM_MAX) begin
          level_d = LVL_MAX;
        end else if (sum < SUM_MIN) begin
          level_d = LVL_MIN;
        end else begin
          level_d = sum[LVL_W-1:0];
        end
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dfx_q   <= dfx_d;
    dy_q    <= dy_d;
    dx_q    <= dx_d;
    ly_q    <= ly_d;
    prod_q  <= prod_d;
    den_q   <= den_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    neg_q   <= neg_d;
    cnt_q   <= cnt_d;
    level_q <= level_d;
  end

  assign done_o  = done_q;
  assign level_o = level_q;

endmodule

### rtl/bcd_back.sv
// ----------------------------------------------------------------------------
// bcd_back: command execution
// Drives both list units and the interpolator, and holds the result register.
// ----------------------------------------------------------------------------
module bcd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_vld_i,
  input  bcd_pkg::cmd_t       cmd_i,
  output logic                cmd_pop_o,
  output bcd_pkg::list_req_t  req_meas_o,
  output bcd_pkg::list_req_t  req_want_o,
  input  bcd_pkg::list_rsp_t  rsp_meas_i,
  input  bcd_pkg::list_rsp_t  rsp_want_i,
  output logic                empty,
  input  logic                pop,
  output bcd_pkg::result_t    result_o
);
  import bcd_pkg::*;

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_LIST  = 3'd1;
  localparam logic [2:0] B_INT_W = 3'd2;
  localparam logic [2:0] B_INT_M = 3'd3;
  localparam logic [2:0] B_OUT   = 3'd4;

  logic [2:0]              state_q, state_d;
  op_e                     op_q, op_d;
  logic [FREQ_W-1:0]       f_q, f_d;
  logic                    need_m_q, need_m_d, need_w_q, need_w_d;
  logic signed [LVL_W-1:0] lvl_w_q, lvl_w_d;
  result_t                 res_q, res_d, out_q, out_d;
  logic                    out_vld_q, out_vld_d;

  logic                    i_start, i_done;
  bracket_t                i_brk;
  logic signed [LVL_W-1:0] i_level;
  logic                    m_left, w_left;

  bcd_interp u_interp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(i_start),
    .freq_i (f_q),
    .brk_i  (i_brk),
    .done_o (i_done),
    .level_o(i_level)
  );

  // desired curve first, then measured
  assign i_brk  = (state_q == B_INT_W) ? rsp_meas_i.brk : rsp_want_i.brk;
  assign m_left = need_m_q && !rsp_meas_i.done;
  assign w_left = need_w_q && !rsp_want_i.done;

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    f_d        = f_q;
    need_m_d   = need_m_q;
    need_w_d   = need_w_q;
    lvl_w_d    = lvl_w_q;
    res_d      = res_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && !pop;
    cmd_pop_o  = 1'b0;
    i_start    = 1'b0;
    req_meas_o = '{start: 1'b0, op: LOP_FIND, freq: cmd_i.freq, level: cmd_i.level};
    req_want_o = '{start: 1'b0, op: LOP_FIND, freq: cmd_i.freq, level: cmd_i.level};

    case (state_q)
      B_IDLE: begin
        if (cmd_vld_i) begin
          cmd_pop_o = 1'b1;
          op_d      = cmd_i.op;
          f_d       = cmd_i.freq;
          res_d     = '{gain_db: '0, status: ST_OK};
          case (cmd_i.op)
            OP_CLEAR: begin
              req_meas_o.start = 1'b1;
              req_meas_o.op    = LOP_CLEAR;
              req_want_o.start = 1'b1;
              req_want_o.op    = LOP_CLEAR;
              state_d          = B_OUT;
            end
            OP_ADD_MEAS: begin
              req_meas_o.start = 1'b1;
              req_meas_o.op    = LOP_ADD;
              need_m_d         = 1'b1;
              need_w_d         = 1'b0;
              state_d          = B_LIST;
            end
            OP_ADD_WANT: begin
              req_want_o.start = 1'b1;
              req_want_o.op    = LOP_ADD;
              need_m_d         = 1'b0;
              need_w_d         = 1'b1;
              state_d          = B_LIST;
            end
            OP_QUERY: begin
              req_meas_o.start = 1'b1;
              req_want_o.start = 1'b1;
              need_m_d         = 1'b1;
              need_w_d         = 1'b1;
              state_d          = B_LIST;
            end
            default: begin
              state_d = B_OUT;
            end
          endcase
        end
      end

      // lists may finish on different cycles
      B_LIST: begin
        need_m_d = m_left;
        need_w_d = w_left;
        if (!m_left && !w_left) begin
          if (op_q == OP_QUERY) begin
            i_start = 1'b1;
            state_d = B_INT_W;
          end else begin
            res_d.status = (op_q == OP_ADD_MEAS) ? rsp_meas_i.status : rsp_want_i.status;
            state_d      = B_OUT;
          end
        end
      end

      B_INT_W: begin
        if (i_done) begin
          lvl_w_d = i_level;
          i_start = 1'b1;
          state_d = B_INT_M;
        end
      end

      B_INT_M: begin
        if (i_done) begin
          res_d.gain_db = $signed({lvl_w_q[LVL_W-1], lvl_w_q})
                        - $signed({i_level[LVL_W-1], i_level});
          state_d       = B_OUT;
        end
      end

      B_OUT: begin
        if (!out_vld_q || pop) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = B_IDLE;
        end
      end

      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_IDLE;
      need_m_q  <= 1'b0;
      need_w_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      need_m_q  <= need_m_d;
      need_w_q  <= need_w_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    f_q     <= f_d;
    lvl_w_q <= lvl_w_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign empty    = !out_vld_q;
  assign result_o = out_q;

endmodule

### rtl/breakpoint_curve_difference.sv
// Operation: a query searches both lists and interpolates each curve with the serial
//   divide; an add searches one list, then shifts the entries above the insert position
//   up one at a time in the list RAM before it writes the new point; clear empties both.
// Throughput: one item at a time in the back end; two items queue up front, one result
//   waits in the output register. Reset: lists empty, queues empty, half_rate = 24000.
// ----------------------------------------------------------------------------
// breakpoint_curve_difference: desired minus measured level at a frequency
// Two sorted breakpoint lists in RAM, searched by bisection and interpolated
// linearly with a truncating serial divide. Result in Q9.8 dB.
// ----------------------------------------------------------------------------
module breakpoint_curve_difference #(
  parameter int MAX_POINTS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input queue side
  input  logic                       push,
  output logic                       full,
  input  bcd_pkg::item_t             item_i,
  // result queue side
  output logic                       empty,
  input  logic                       pop,
  output bcd_pkg::result_t           result_o,
  // configuration: half_rate
  input  logic                       cfg_we_i,
  input  logic [bcd_pkg::FREQ_W-1:0] cfg_wdata_i
);
  import bcd_pkg::*;

  logic [FREQ_W-1:0] half_rate_q;

  logic      cmd_vld, cmd_pop;
  cmd_t      cmd;
  list_req_t req_meas, req_want;
  list_rsp_t rsp_meas, rsp_want;

  // half_rate must only be written while the block is idle; the block itself does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_rate_q <= HALF_RATE_RST;
    end else if (cfg_we_i) begin
      half_rate_q <= cfg_wdata_i;
    end
  end

  // Front end: a transfer on push lands here decoded into a command; a
  // two-entry queue lets intake run ahead of the back end.
  bcd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .item_i   (item_i),
    .cmd_vld_o(cmd_vld),
    .cmd_o    (cmd),
    .cmd_pop_i(cmd_pop)
  );

  // Measured curve. Each list keeps its points strictly ascending in RAM;
  // contents past the count are never used, so the RAM needs no clearing.
  bcd_list #(
    .MAX_POINTS(MAX_POINTS)
  ) u_meas (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_meas),
    .half_rate_i(half_rate_q),
    .rsp_o      (rsp_meas)
  );

  // Desired curve; searched in parallel with the measured one on a query.
  bcd_list #(
    .MAX_POINTS(MAX_POINTS)
  ) u_want (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_want),
    .half_rate_i(half_rate_q),
    .rsp_o      (rsp_want)
  );

  // Back end: sequences list operations and the shared interpolator, then
  // parks one result in the output register until it is popped.
  bcd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_vld_i (cmd_vld),
    .cmd_i     (cmd),
    .cmd_pop_o (cmd_pop),
    .req_meas_o(req_meas),
    .req_want_o(req_want),
    .rsp_meas_i(rsp_meas),
    .rsp_want_i(rsp_want),
    .empty     (empty),
    .pop       (pop),
    .result_o  (result_o)
  );

endmodule
